[hdl/ipt_pkg.sv]
// shared types, constants and helpers for the ipv4 prefix table
`default_nettype none

package ipt_pkg;

    localparam int ADDR_W            = 32;
    localparam int LEN_W             = 6;
    localparam int VAL_W             = 16;
    localparam int MODE_W            = 2;
    localparam int STATUS_W          = 2;
    localparam int MAX_LEN           = 32;
    localparam int DEF_TABLE_ENTRIES = 256;

    typedef enum logic [MODE_W-1:0] {
        MODE_INSERT  = 2'd0,
        MODE_REMOVE  = 2'd1,
        MODE_NEAREST = 2'd2,
        MODE_EXACT   = 2'd3
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] prefix;
        logic [LEN_W-1:0]  length;
        logic [VAL_W-1:0]  value;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // controller to datapath
    typedef struct packed {
        logic start;
        logic scan;
        logic clear;
        logic commit;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic scan_last;
        logic out_free;
    } t_dp_status;

    // leading-ones mask of a prefix length, length at most MAX_LEN
    function automatic logic [ADDR_W-1:0] len_mask(input logic [LEN_W-1:0] len);
        logic [ADDR_W-1:0] mask;
        mask = '0;
        if (len != '0) begin
            mask = {ADDR_W{1'b1}} << (LEN_W'(ADDR_W) - len);
        end
        return mask;
    endfunction

endpackage

`default_nettype wire

[hdl/ipt_req_if.sv]
// request channel: valid/ready handshake with the request fields
`default_nettype none

interface ipt_req_if import ipt_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [ADDR_W-1:0] address;
    logic [LEN_W-1:0]  prefix_len;
    logic [VAL_W-1:0]  new_value;

    modport source (output valid, mode, address, prefix_len, new_value, input ready);
    modport sink   (input valid, mode, address, prefix_len, new_value, output ready);
endinterface

`default_nettype wire

[hdl/ipt_rsp_if.sv]
// response channel: valid/ready handshake with the result fields
`default_nettype none

interface ipt_rsp_if import ipt_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [VAL_W-1:0]    value_out;
    logic [STATUS_W-1:0] status;

    modport source (output valid, value_out, status, input ready);
    modport sink   (input valid, value_out, status, output ready);
endinterface

`default_nettype wire

[hdl/ipt_ram.sv]
// generic simple dual-port ram, one write port, one registered read port
`default_nettype none

module ipt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

[hdl/ipt_ctrl.sv]
// sequencer for clearing, scanning and committing table requests
`default_nettype none

module ipt_ctrl import ipt_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_req_valid,
    output logic            o_req_ready,
    input  wire t_dp_status i_status,
    output t_dp_cmd         o_cmd
);

    typedef enum logic [4:0] {
        S_CLEAR  = 5'b00001,
        S_IDLE   = 5'b00010,
        S_SCAN   = 5'b00100,
        S_DRAIN  = 5'b01000,
        S_COMMIT = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_req_ready = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_status.scan_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_status.scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            // last entry read is evaluated here
            S_DRAIN: begin
                n_state = S_COMMIT;
            end
            S_COMMIT: begin
                if (i_status.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

endmodule

`default_nettype wire

[hdl/ipt_dp.sv]
// datapath: request registers, entry scan, match tracking and result register
`default_nettype none

module ipt_dp import ipt_pkg::*; #(
    parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_dp_cmd             i_cmd,
    output t_dp_status               o_status,
    input  wire logic [MODE_W-1:0]   i_mode,
    input  wire logic [ADDR_W-1:0]   i_address,
    input  wire logic [LEN_W-1:0]    i_prefix_len,
    input  wire logic [VAL_W-1:0]    i_new_value,
    input  wire logic                i_rsp_ready,
    output logic                     o_rsp_valid,
    output logic [VAL_W-1:0]         o_value_out,
    output logic [STATUS_W-1:0]      o_status_out
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    // request
    t_mode             r_mode;
    logic [ADDR_W-1:0] r_addr;
    logic [ADDR_W-1:0] r_key;
    logic [LEN_W-1:0]  r_len;
    logic [VAL_W-1:0]  r_nval;

    // scan
    logic [IDX_W-1:0]  r_scan_addr;
    logic              r_rd_vld;
    logic [IDX_W-1:0]  r_rd_idx;

    // match tracking
    logic              r_hit;
    logic [IDX_W-1:0]  r_hit_idx;
    logic [VAL_W-1:0]  r_hit_val;
    logic              r_free;
    logic [IDX_W-1:0]  r_free_idx;
    logic              r_best;
    logic [LEN_W-1:0]  r_best_len;
    logic [VAL_W-1:0]  r_best_val;

    // result
    logic              r_out_vld;
    logic [VAL_W-1:0]  r_out_val;
    t_status           r_out_st;

    logic [LEN_W-1:0]   n_len;
    logic [ENTRY_W-1:0] rd_data;
    t_entry             rd_entry;
    logic               exact_match;
    logic               near_match;
    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    t_entry             ram_wentry;
    logic               dec_we;
    logic [IDX_W-1:0]   dec_waddr;
    t_entry             dec_wentry;
    logic [VAL_W-1:0]   dec_val;
    t_status            dec_st;

    assign n_len = (i_prefix_len > LEN_W'(MAX_LEN)) ? LEN_W'(MAX_LEN) : i_prefix_len;

    assign rd_entry    = t_entry'(rd_data);
    assign exact_match = rd_entry.valid && (rd_entry.length == r_len)
                         && (rd_entry.prefix == r_key);
    assign near_match  = rd_entry.valid && (rd_entry.length <= r_len)
                         && ((r_addr & len_mask(rd_entry.length)) == rd_entry.prefix);

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_mode <= t_mode'(i_mode);
            r_addr <= i_address;
            r_key  <= i_address & len_mask(n_len);
            r_len  <= n_len;
            r_nval <= i_new_value;
            r_hit  <= 1'b0;
            r_free <= 1'b0;
            r_best <= 1'b0;
        end else if (r_rd_vld) begin
            if (exact_match && !r_hit) begin
                r_hit     <= 1'b1;
                r_hit_idx <= r_rd_idx;
                r_hit_val <= rd_entry.value;
            end
            // lowest free entry wins
            if (!rd_entry.valid && !r_free) begin
                r_free     <= 1'b1;
                r_free_idx <= r_rd_idx;
            end
            // strictly longer only, so the lowest index wins a tie
            if (near_match && (!r_best || rd_entry.length > r_best_len)) begin
                r_best     <= 1'b1;
                r_best_len <= rd_entry.length;
                r_best_val <= rd_entry.value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_addr <= '0;
            r_rd_vld    <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.scan;
            if (i_cmd.start) begin
                r_scan_addr <= '0;
            end else if (i_cmd.scan || i_cmd.clear) begin
                r_scan_addr <= r_scan_addr + 1'b1;
            end
            if (i_cmd.commit) begin
                r_out_vld <= 1'b1;
            end else if (i_rsp_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_scan_addr;
        if (i_cmd.commit) begin
            r_out_val <= dec_val;
            r_out_st  <= dec_st;
        end
    end

    // final decision once the whole table is scanned
    always_comb begin
        dec_we     = 1'b0;
        dec_waddr  = r_hit_idx;
        dec_wentry = '0;
        dec_val    = '0;
        dec_st     = ST_OK;
        unique case (r_mode)
            MODE_INSERT: begin
                if (r_hit) begin
                    dec_val = r_hit_val;
                end else if (r_nval != '0) begin
                    if (r_free) begin
                        dec_we            = 1'b1;
                        dec_waddr         = r_free_idx;
                        dec_wentry.valid  = 1'b1;
                        dec_wentry.prefix = r_key;
                        dec_wentry.length = r_len;
                        dec_wentry.value  = r_nval;
                        dec_val           = r_nval;
                    end else begin
                        dec_st = ST_FULL;
                    end
                end
            end
            MODE_REMOVE: begin
                if (r_hit) begin
                    dec_we  = 1'b1;
                    dec_val = r_hit_val;
                end else begin
                    dec_st = ST_NOT_FOUND;
                end
            end
            MODE_NEAREST: begin
                if (r_best) begin
                    dec_val = r_best_val;
                end else begin
                    dec_st = ST_NOT_FOUND;
                end
            end
            MODE_EXACT: begin
                if (r_hit) begin
                    dec_val = r_hit_val;
                end else begin
                    dec_st = ST_NOT_FOUND;
                end
            end
            default: begin
                dec_st = ST_NOT_FOUND;
            end
        endcase
    end

    assign ram_we     = i_cmd.clear || (i_cmd.commit && dec_we);
    assign ram_waddr  = i_cmd.clear ? r_scan_addr : dec_waddr;
    assign ram_wentry = i_cmd.clear ? t_entry'('0) : dec_wentry;

    ipt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (ram_waddr),
        .i_wr_data (ram_wentry),
        .i_rd_addr (r_scan_addr),
        .o_rd_data (rd_data)
    );

    assign o_status.scan_last = (r_scan_addr == LAST_IDX);
    assign o_status.out_free  = !r_out_vld || i_rsp_ready;

    assign o_rsp_valid  = r_out_vld;
    assign o_value_out  = r_out_val;
    assign o_status_out = r_out_st;

endmodule

`default_nettype wire

[hdl/ipv4_prefix_table.sv]
// top level of the ipv4 longest-prefix-match table
//
//  channel  dir  handshake       payload
//  i_req    in   valid / ready   mode, address, prefix_len, new_value
//  o_rsp    out  valid / ready   value_out, status
//
// each request scans every entry, one per cycle through the table ram read
// port, then passes through a drain step for the last read and a commit step
// that registers the result; the next request is taken back in idle
// after reset a clearing pass over every entry runs before the first
// request is taken
// one request at a time; the next is accepted while the result waits in the
// output register, and a stalled output only holds the final commit step
`default_nettype none

module ipv4_prefix_table import ipt_pkg::*; #(
    parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    ipt_req_if.sink    i_req,
    ipt_rsp_if.source  o_rsp
);

    t_dp_cmd    cmd;
    t_dp_status dp_status;
    logic       req_ready;

    ipt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (req_ready),
        .i_status    (dp_status),
        .o_cmd       (cmd)
    );

    ipt_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_status     (dp_status),
        .i_mode       (i_req.mode),
        .i_address    (i_req.address),
        .i_prefix_len (i_req.prefix_len),
        .i_new_value  (i_req.new_value),
        .i_rsp_ready  (o_rsp.ready),
        .o_rsp_valid  (o_rsp.valid),
        .o_value_out  (o_rsp.value_out),
        .o_status_out (o_rsp.status)
    );

    assign i_req.ready = req_ready;

endmodule

`default_nettype wire
